[sv/erx_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the escaped frame receiver.
// Used by the parser front end, the frame emitter and the top level.
package erx_pkg;

    localparam int unsigned CODE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CODE_W-1:0] START_RESET = 8'd18;
    localparam logic [CODE_W-1:0] STOP_RESET = 8'd19;
    localparam logic [CODE_W-1:0] ESCAPE_RESET = 8'd125;

    // Parser states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READING = 2'd1;
    localparam logic [1:0] ST_ESCAPE = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    // Handback of a buffer bank from the emitter to the parser.
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    // One entry of the output queue.
    typedef struct packed {
        logic [CODE_W-1:0] data;
        logic last;
        logic dropped;
    } out_item_t;

endpackage

[sv/erx_queue.sv]
`timescale 1ns / 1ps
// Two-entry command queue between the frame parser and the frame emitter.
// Depends on nothing but its WIDTH parameter.
module erx_queue #(
    parameter int unsigned WIDTH = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/erx_front.sv]
`timescale 1ns / 1ps
// Frame parser: holds the code registers, decodes received bytes, writes the
// frame buffer and queues at most one command per completed frame. Uses erx_pkg.
module erx_front
    import erx_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 16,
    parameter int unsigned LEN_W = 5,
    parameter int unsigned AW = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CODE_W-1:0]    rx_byte,
    input  logic [CODE_W-1:0]    sink_free,
    output logic                 cmd_push,
    output logic [LEN_W+1:0]     cmd_data,
    input  logic                 cmd_full,
    input  release_t             bank_release,
    output logic                 buf_we,
    output logic [AW-1:0]        buf_addr,
    output logic [CODE_W-1:0]    buf_wdata
);

    localparam int unsigned CW = (LEN_W > CODE_W) ? LEN_W : CODE_W;

    logic [CODE_W-1:0] start_code_reg;
    logic [CODE_W-1:0] stop_code_reg;
    logic [CODE_W-1:0] escape_code_reg;
    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              bank_reg;
    logic              bank_next;
    logic [1:0]        busy_reg;
    logic [1:0]        busy_next;
    logic              accept;
    logic              full_frame;
    logic              store;
    logic              emit;
    logic              deliver;

    // A byte is taken only when the bank it may fill is free and a command
    // for a closing frame is sure to fit in the queue.
    assign in_ready = !busy_reg[bank_reg] && !cmd_full;
    assign accept = in_valid && in_ready;
    assign full_frame = (len_reg == LEN_W'(MAX_FRAME));
    assign deliver = (CW'(sink_free) > CW'(len_reg));

    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        store = 1'b0;
        emit = 1'b0;
        if (accept)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == start_code_reg)
                    begin
                        state_next = ST_READING;
                        len_next = '0;
                    end
                end
                ST_READING:
                begin
                    if (full_frame)
                    begin
                        state_next = ST_ERROR;
                    end
                    else if (rx_byte == stop_code_reg)
                    begin
                        state_next = ST_IDLE;
                        emit = 1'b1;
                    end
                    else if (rx_byte == escape_code_reg)
                    begin
                        state_next = ST_ESCAPE;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
                ST_ESCAPE:
                begin
                    if (full_frame)
                    begin
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        store = 1'b1;
                        state_next = ST_READING;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    len_next = '0;
                end
            endcase
        end
        if (store)
        begin
            len_next = len_reg + 1'b1;
        end
    end

    // An empty frame with room downstream produces nothing at all.
    always_comb
    begin
        cmd_push = 1'b0;
        cmd_data = {1'b1, bank_reg, len_reg};
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (bank_release.valid)
        begin
            busy_next[bank_release.bank] = 1'b0;
        end
        if (emit)
        begin
            if (deliver)
            begin
                if (len_reg != '0)
                begin
                    cmd_push = 1'b1;
                    cmd_data = {1'b0, bank_reg, len_reg};
                    busy_next[bank_reg] = 1'b1;
                    bank_next = !bank_reg;
                end
            end
            else
            begin
                cmd_push = 1'b1;
            end
        end
    end

    assign buf_we = store;
    assign buf_addr = (bank_reg ? AW'(MAX_FRAME) : AW'(0)) + AW'(len_reg);
    assign buf_wdata = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_RESET;
            stop_code_reg <= STOP_RESET;
            escape_code_reg <= ESCAPE_RESET;
            state_reg <= ST_IDLE;
            len_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= 2'b00;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START: start_code_reg <= cfg_data;
                    REG_STOP: stop_code_reg <= cfg_data;
                    REG_ESCAPE: escape_code_reg <= cfg_data;
                    default: ;
                endcase
            end
            state_reg <= state_next;
            len_reg <= len_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

[sv/erx_back.sv]
`timescale 1ns / 1ps
// Frame emitter: owns the two-bank frame buffer, plays queued commands out
// as result bytes or drop notices and hands banks back. Uses erx_pkg.
module erx_back
    import erx_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 16,
    parameter int unsigned LEN_W = 5,
    parameter int unsigned AW = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              buf_we,
    input  logic [AW-1:0]     buf_addr,
    input  logic [CODE_W-1:0] buf_wdata,
    input  logic              cmd_valid,
    input  logic [LEN_W+1:0]  cmd_data,
    output logic              cmd_pop,
    output release_t          bank_release,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] data_byte,
    output logic              last,
    output logic              dropped
);

    localparam int unsigned DEPTH = 2 * MAX_FRAME;

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    logic              active_reg;
    logic              active_next;
    logic              drop_reg;
    logic              bank_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  idx_next;

    logic              s1_valid_reg;
    logic              s1_mem_reg;
    logic              s1_last_reg;
    logic              s1_drop_reg;

    out_item_t         fifo_reg [2];
    logic              fifo_wr_reg;
    logic              fifo_rd_reg;
    logic [1:0]        fifo_cnt_reg;
    logic [2:0]        occupancy;
    logic              out_pop;
    logic              issue;
    logic              issue_last;
    logic [AW-1:0]     rd_addr;
    out_item_t         s1_item;

    assign out_pop = out_valid && out_ready;
    // Entries already queued or on their way from the buffer read, less the
    // one that leaves now, must leave room for one more.
    assign occupancy = 3'(fifo_cnt_reg) + 3'(s1_valid_reg) - 3'(out_pop);
    assign issue = active_reg && (occupancy < 3'd2);
    assign issue_last = drop_reg || (idx_reg == len_reg - 1'b1);
    assign cmd_pop = !active_reg && cmd_valid;
    assign rd_addr = (bank_reg ? AW'(MAX_FRAME) : AW'(0)) + AW'(idx_reg);

    always_comb
    begin
        active_next = active_reg;
        idx_next = idx_reg;
        bank_release.valid = 1'b0;
        bank_release.bank = bank_reg;
        if (cmd_pop)
        begin
            active_next = 1'b1;
            idx_next = '0;
        end
        else if (issue)
        begin
            if (issue_last)
            begin
                active_next = 1'b0;
                bank_release.valid = !drop_reg;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_item.data = s1_mem_reg ? rd_data_reg : '0;
        s1_item.last = s1_last_reg;
        s1_item.dropped = s1_drop_reg;
    end

    assign out_valid = (fifo_cnt_reg != 2'd0);
    assign data_byte = fifo_reg[fifo_rd_reg].data;
    assign last = fifo_reg[fifo_rd_reg].last;
    assign dropped = fifo_reg[fifo_rd_reg].dropped;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            mem[buf_addr] <= buf_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            drop_reg <= cmd_data[LEN_W+1];
            bank_reg <= cmd_data[LEN_W];
            len_reg <= cmd_data[LEN_W-1:0];
        end
        if (issue)
        begin
            s1_mem_reg <= !drop_reg;
            s1_last_reg <= issue_last;
            s1_drop_reg <= drop_reg;
        end
        if (s1_valid_reg)
        begin
            fifo_reg[fifo_wr_reg] <= s1_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            fifo_wr_reg <= 1'b0;
            fifo_rd_reg <= 1'b0;
            fifo_cnt_reg <= 2'd0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg <= idx_next;
            s1_valid_reg <= issue;
            fifo_wr_reg <= fifo_wr_reg ^ s1_valid_reg;
            fifo_rd_reg <= fifo_rd_reg ^ out_pop;
            fifo_cnt_reg <= fifo_cnt_reg + 2'(s1_valid_reg) - 2'(out_pop);
        end
    end

endmodule

[sv/escaped_frame_receiver_top.sv]
`timescale 1ns / 1ps
// Top level of the escaped frame receiver: parser, command queue and emitter.
// Depends on erx_pkg, erx_front, erx_queue and erx_back.

// The receiver takes one byte per cycle while it parses a frame. Frames are
// stored in one of two buffer banks; when a stop code closes a frame, a
// command goes into a two-entry queue (none for an empty frame with room
// downstream) and the emitter plays the frame out at one byte per cycle
// while the output is taken, as the parser goes on with the next frame in
// the other bank. Input stalls only while the bank the parser would fill is
// still being read out, or while the command queue is full. A drop notice is
// a single output entry. The buffer needs no clearing after reset: only bytes
// written in the current frame are ever read.
module escaped_frame_receiver_top
    import erx_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CODE_W-1:0]    rx_byte,
    input  logic [CODE_W-1:0]    sink_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CODE_W-1:0]    data_byte,
    output logic                 last,
    output logic                 dropped
);

    localparam int unsigned LEN_W = $clog2(MAX_FRAME + 1);
    localparam int unsigned AW = $clog2(2 * MAX_FRAME);
    localparam int unsigned CMD_W = LEN_W + 2;

    logic              cmd_push;
    logic [CMD_W-1:0]  cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_valid;
    logic [CMD_W-1:0]  cmd_out;
    release_t          bank_release;
    logic              buf_we;
    logic [AW-1:0]     buf_addr;
    logic [CODE_W-1:0] buf_wdata;

    erx_front #(
        .MAX_FRAME (MAX_FRAME),
        .LEN_W     (LEN_W),
        .AW        (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .sink_free    (sink_free),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .cmd_full     (cmd_full),
        .bank_release (bank_release),
        .buf_we       (buf_we),
        .buf_addr     (buf_addr),
        .buf_wdata    (buf_wdata)
    );

    erx_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd_in),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head_data  (cmd_out)
    );

    erx_back #(
        .MAX_FRAME (MAX_FRAME),
        .LEN_W     (LEN_W),
        .AW        (AW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .buf_we       (buf_we),
        .buf_addr     (buf_addr),
        .buf_wdata    (buf_wdata),
        .cmd_valid    (cmd_valid),
        .cmd_data     (cmd_out),
        .cmd_pop      (cmd_pop),
        .bank_release (bank_release),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .last         (last),
        .dropped      (dropped)
    );

endmodule
